// ===== design/gbr_pkg.sv =====
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants of the 3x3 RGB blur
// Pixel, column and partial-sum types, frame limits and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = ADDR_W + 1;
	localparam int CFG_W     = 12;
	localparam int CMP_W     = (WIDTH_W > CFG_W) ? WIDTH_W : CFG_W;
	localparam int ROW_W     = 12;

	localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

	localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
	localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] ch2;
		logic [7:0] ch1;
		logic [7:0] ch0;
	} pix_t;

	// one window column: upper row, middle row, newest row
	typedef struct packed {
		pix_t up;
		pix_t mid;
		pix_t low;
	} col_t;

	// one line buffer entry: rows r-2 and r-1 at a column
	typedef struct packed {
		pix_t up;
		pix_t mid;
	} line_t;

	// 1-2-1 weighted column sum per channel
	typedef struct packed {
		logic [9:0] ch2;
		logic [9:0] ch1;
		logic [9:0] ch0;
	} vsum_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic last;
	} ctrl_t;

	function automatic logic [9:0] tap_sum(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		tap_sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
	endfunction

	function automatic vsum_t col_vsum(input col_t c);
		vsum_t v;
		v.ch0 = tap_sum(c.up.ch0, c.mid.ch0, c.low.ch0);
		v.ch1 = tap_sum(c.up.ch1, c.mid.ch1, c.low.ch1);
		v.ch2 = tap_sum(c.up.ch2, c.mid.ch2, c.low.ch2);
		col_vsum = v;
	endfunction

endpackage

`default_nettype wire

// ===== design/gaussian_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb: streaming 3x3 Gaussian blur, three 8-bit channels
// Throughput: one request per cycle; stalls only while the output skid is full.
// Path: request -> stage 1 -> stage 2 -> output register -> m_tvalid; a result
// trails its pixel by frame_width+1 requests (drain requests flush the tail).
// Reset: counters and window clear, width 640, height 480; line buffers uncleared.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_rgb (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // chan0_in, chan1_in, chan2_in
	input  wire logic        s_tuser,   // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // chan0_out, chan1_out, chan2_out
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_wdata
);

	localparam int ADDR_W = gbr_pkg::ADDR_W;
	localparam int CMP_W  = gbr_pkg::CMP_W;
	localparam int CFG_W  = gbr_pkg::CFG_W;
	localparam int ROW_W  = gbr_pkg::ROW_W;

	// configuration
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [CMP_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;

	// positions
	logic [ADDR_W-1:0] in_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [ADDR_W-1:0] out_col_q;
	logic [ROW_W-1:0]  out_row_q;

	logic en;
	logic take;
	logic complete;
	logic in_col_end;
	logic out_col_end;
	logic out_row_end;
	gbr_pkg::ctrl_t ctrl;
	gbr_pkg::pix_t  pix_in;

	// stage 1
	logic              vld_s1;
	gbr_pkg::pix_t     pix_s1;
	logic [ADDR_W-1:0] addr_s1;
	gbr_pkg::ctrl_t    ctrl_s1;
	logic              byp_s1;
	gbr_pkg::line_t    fwd_s1;

	gbr_pkg::line_t rdata;
	gbr_pkg::line_t line_rd;
	gbr_pkg::line_t wdata;
	gbr_pkg::col_t  col_new;
	gbr_pkg::vsum_t vsum_new;
	logic           load;

	gbr_pkg::col_t  col_q  [3];
	gbr_pkg::vsum_t vsum_q [3];

	// stage 2
	logic           vld_s2;
	gbr_pkg::ctrl_t ctrl_s2;
	gbr_pkg::pix_t  result;
	logic           push;

	// output register and skid
	logic          out_vld_q;
	gbr_pkg::pix_t out_pix_q;
	logic          out_last_q;
	logic          skid_vld_q;
	gbr_pkg::pix_t skid_pix_q;
	logic          skid_last_q;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = CMP_W'(1);
		end else if (CMP_W'(frame_width_q) > CMP_W'(gbr_pkg::MAX_WIDTH)) begin
			w_eff = CMP_W'(gbr_pkg::MAX_WIDTH);
		end else begin
			w_eff = CMP_W'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? CFG_W'(1) : frame_height_q;
	end

	always_comb begin
		complete    = in_row_q >= h_eff;
		take        = s_tvalid && s_tready && (complete || !s_tuser);
		pix_in      = complete ? '0 : gbr_pkg::pix_t'(s_tdata);
		in_col_end  = (CMP_W'(in_col_q) + CMP_W'(1)) >= w_eff;
		out_col_end = (CMP_W'(out_col_q) + CMP_W'(1)) >= w_eff;
		out_row_end = ({1'b0, out_row_q} + 13'd1) >= {1'b0, h_eff};
		ctrl.emit   = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
		ctrl.border = (out_row_q == '0) || out_row_end || (out_col_q == '0) || out_col_end;
		ctrl.last   = out_row_end && out_col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gbr_pkg::RESET_WIDTH;
			frame_height_q <= gbr_pkg::RESET_HEIGHT;
		end else if (cfg_we) begin
			case (gbr_pkg::cfg_index_t'(cfg_index))
				gbr_pkg::CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_wdata;
				end
				gbr_pkg::CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we || (take && ctrl.emit && ctrl.last)) begin
			// restart the frame
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (ctrl.emit) begin
				if (out_col_end) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + ADDR_W'(1);
				end
			end
			if (in_col_end) begin
				in_col_q <= '0;
				if (in_row_q != gbr_pkg::ROW_MAX) begin
					in_row_q <= in_row_q + ROW_W'(1);
				end
			end else begin
				in_col_q <= in_col_q + ADDR_W'(1);
			end
		end
	end

	// stage 1: request registered, line buffer read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= take;
			// the read below misses a write to the same column in this cycle
			byp_s1 <= vld_s1 && (addr_s1 == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= pix_in;
			addr_s1 <= in_col_q;
			ctrl_s1 <= ctrl;
			fwd_s1  <= wdata;
		end
	end

	gbr_line_mem u_line_mem (
		.clk     (clk),
		.en      (en),
		.we      (vld_s1),
		.waddr   (addr_s1),
		.wdata   (wdata),
		.raddr   (in_col_q),
		.rdata_q (rdata)
	);

	always_comb begin
		line_rd      = byp_s1 ? fwd_s1 : rdata;
		wdata.up     = line_rd.mid;
		wdata.mid    = pix_s1;
		col_new.up   = line_rd.up;
		col_new.mid  = line_rd.mid;
		col_new.low  = pix_s1;
		vsum_new     = gbr_pkg::col_vsum(col_new);
		load         = en && vld_s1;
	end

	// window: newest column enters the right cell and moves left
	gbr_col_cell u_cell_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.col_in  (col_new),
		.vsum_in (vsum_new),
		.col_q   (col_q[2]),
		.vsum_q  (vsum_q[2])
	);

	gbr_col_cell u_cell_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.col_in  (col_q[2]),
		.vsum_in (vsum_q[2]),
		.col_q   (col_q[1]),
		.vsum_q  (vsum_q[1])
	);

	gbr_col_cell u_cell_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.col_in  (col_q[1]),
		.vsum_in (vsum_q[1]),
		.col_q   (col_q[0]),
		.vsum_q  (vsum_q[0])
	);

	// stage 2: window holds this request's neighborhood
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1 && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	gbr_kernel u_kernel (
		.vs_left  (vsum_q[0]),
		.vs_mid   (vsum_q[1]),
		.vs_right (vsum_q[2]),
		.center   (col_q[1].mid),
		.border   (ctrl_s2.border),
		.result   (result)
	);

	assign push = en && vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_vld_q || m_tready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_tready) begin
				out_pix_q  <= skid_pix_q;
				out_last_q <= skid_last_q;
			end
		end else if (push) begin
			if (!out_vld_q || m_tready) begin
				out_pix_q  <= result;
				out_last_q <= ctrl_s2.last;
			end else begin
				// hold the result until the output frees up
				skid_pix_q  <= result;
				skid_last_q <= ctrl_s2.last;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== design/gbr_col_cell.sv =====
// ----------------------------------------------------------------------------
// gbr_col_cell: one column of the 3x3 window
// Holds three pixels and their weighted column sum; loads from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_col_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire gbr_pkg::col_t  col_in,
	input  wire gbr_pkg::vsum_t vsum_in,
	output gbr_pkg::col_t      col_q,
	output gbr_pkg::vsum_t     vsum_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			vsum_q <= '0;
		end else if (load) begin
			col_q  <= col_in;
			vsum_q <= vsum_in;
		end
	end

endmodule

`default_nettype wire

// ===== design/gbr_line_mem.sv =====
// ----------------------------------------------------------------------------
// gbr_line_mem: line buffer memory
// One write and one registered read per enabled cycle; read returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_line_mem (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic                      we,
	input  wire logic [gbr_pkg::ADDR_W-1:0] waddr,
	input  wire gbr_pkg::line_t            wdata,
	input  wire logic [gbr_pkg::ADDR_W-1:0] raddr,
	output gbr_pkg::line_t                 rdata_q
);

	gbr_pkg::line_t mem [gbr_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/gbr_kernel.sv =====
// ----------------------------------------------------------------------------
// gbr_kernel: horizontal 1-2-1 combine of three column sums
// Selects the center pixel on border positions.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_kernel (
	input  wire gbr_pkg::vsum_t vs_left,
	input  wire gbr_pkg::vsum_t vs_mid,
	input  wire gbr_pkg::vsum_t vs_right,
	input  wire gbr_pkg::pix_t  center,
	input  wire logic           border,
	output gbr_pkg::pix_t       result
);

	function automatic logic [7:0] combine(input logic [9:0] a, input logic [9:0] b,
		input logic [9:0] c);
		logic [11:0] total;
		total = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
		combine = total[11:4];
	endfunction

	gbr_pkg::pix_t blur;

	always_comb begin
		blur.ch0 = combine(vs_left.ch0, vs_mid.ch0, vs_right.ch0);
		blur.ch1 = combine(vs_left.ch1, vs_mid.ch1, vs_right.ch1);
		blur.ch2 = combine(vs_left.ch2, vs_mid.ch2, vs_right.ch2);
		result   = border ? center : blur;
	end

endmodule

`default_nettype wire
